// ===== hdl/assert_macros.svh =====
// Assertion helper macros used by the checker file ebzp_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hdl/ebzp_pkg.sv =====
// ----------------------------------------------------------------------------
// ebzp_pkg
// Shared types and constants of the eased Bezier path generator.
// ----------------------------------------------------------------------------
package ebzp_pkg;
	localparam int CoordBits = 20;
	localparam int TimeBits  = 24;
	localparam int StepBits  = 20;
	localparam int PFrac     = 23;
	localparam int CfgIdxBits = 3;

	localparam logic [CfgIdxBits-1:0] REG_START = 3'd0;
	localparam logic [CfgIdxBits-1:0] REG_CTRL  = 3'd1;
	localparam logic [CfgIdxBits-1:0] REG_END   = 3'd2;
	localparam logic [CfgIdxBits-1:0] REG_DUR   = 3'd3;
	localparam logic [CfgIdxBits-1:0] REG_EIN   = 3'd4;
	localparam logic [CfgIdxBits-1:0] REG_EOUT  = 3'd5;

	// Datapath operations, one per controller step.
	typedef enum logic [3:0] {
		OP_NONE, OP_SETUP, OP_DIVR, OP_DIVIN, OP_SMIN1, OP_SMIN2, OP_APPIN,
		OP_DIVOUT, OP_SMOUT1, OP_SMOUT2, OP_APPOUT, OP_INC, OP_WGT1, OP_WGT2,
		OP_ACC, OP_FIN
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       start;    // first cycle of a divider operation
		logic       load;     // a tick request is taken at this edge
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic ein_active;
		logic eout_active;
	} sts_t;
endpackage

// ===== hdl/eased_quadratic_bezier_path.sv =====
// ----------------------------------------------------------------------------
// eased_quadratic_bezier_path
// Eased quadratic Bezier motion generator, one point per time tick.
// ----------------------------------------------------------------------------
// Usage: a tick request (time_step) is taken on in_valid with in_stall low.
// The block then works the tick alone: a shared 40-step restoring divider
// forms the peak rate and up to two ease ratios, and a shared multiplier
// handles the smoothstep, increment and curve weights in turn.
// After a request is taken, the setup step and a divider pass for the
// peak rate run first; each active ease window adds a divider pass and
// its smoothstep scaling, and the increment, weights and three axis sums
// follow before out_valid rises. A new request is taken only once the
// result has left, at the earliest in the cycle after it leaves.
// The result holds on pos_x/y/z and move_done while out_stall is high.
// Configuration writes go through cfg_valid/cfg_ready with cfg_index and
// cfg_data, and are meant only while the block is idle.
// Reset clears the parameter and timer and loads the register defaults.
// ----------------------------------------------------------------------------
module eased_quadratic_bezier_path (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [ebzp_pkg::StepBits-1:0]          time_step,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [ebzp_pkg::CoordBits-1:0]  pos_x,
	output logic signed [ebzp_pkg::CoordBits-1:0]  pos_y,
	output logic signed [ebzp_pkg::CoordBits-1:0]  pos_z,
	output logic                                   move_done,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ebzp_pkg::CfgIdxBits-1:0]        cfg_index,
	input  logic [59:0]                            cfg_data
);
	ebzp_pkg::cmd_t cmd;
	ebzp_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ebzp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	ebzp_datapath u_dp (
		.clk, .arst_n,
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
		.step_in(time_step), .cmd, .sts,
		.px(pos_x), .py(pos_y), .pz(pos_z), .done_flag(move_done)
	);
endmodule

// ===== hdl/ebzp_datapath.sv =====
// ----------------------------------------------------------------------------
// ebzp_datapath
// Registers, shared divider and multiplier of the path generator.
// ----------------------------------------------------------------------------
module ebzp_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ebzp_pkg::CfgIdxBits-1:0]     cfg_idx,
	input  logic [59:0]                         cfg_data,
	input  logic [ebzp_pkg::StepBits-1:0]       step_in,
	input  ebzp_pkg::cmd_t                      cmd,
	output ebzp_pkg::sts_t                      sts,
	output logic signed [ebzp_pkg::CoordBits-1:0] px,
	output logic signed [ebzp_pkg::CoordBits-1:0] py,
	output logic signed [ebzp_pkg::CoordBits-1:0] pz,
	output logic                                done_flag
);
	localparam int TB = ebzp_pkg::TimeBits;
	localparam int CB = ebzp_pkg::CoordBits;
	localparam int PF = ebzp_pkg::PFrac;
	localparam logic [TB-1:0] TMax = '1;
	localparam logic [PF:0] POne = (PF+1)'(1) << PF;

	logic [59:0]   sp_q, cp_q, ep_q;
	logic [TB-1:0] dur_q, ein_q, eout_q, tim_q;
	logic [PF:0]   par_q;
	logic [ebzp_pkg::StepBits-1:0] dt_q;

	// Working registers.
	logic [PF:0]  rate_q;
	logic [16:0]  u_q;
	logic [33:0]  uu_q;
	logic [PF:0]  a_q, b_q, c_q;
	logic signed [CB+PF+3:0] acc_q;
	logic signed [CB-1:0] px_q, py_q, pz_q;
	logic         done_q;

	// Shared restoring divider: quotient up to 40 bits, one bit a cycle.
	logic [39:0]  dnum_q;
	logic [26:0]  drem_q;
	logic [25:0]  dden_q;
	logic [5:0]   dcnt_q;
	logic         dbusy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0; cp_q <= '0; ep_q <= '0;
			dur_q <= TB'(65536); ein_q <= '0; eout_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				ebzp_pkg::REG_START: sp_q <= cfg_data;
				ebzp_pkg::REG_CTRL:  cp_q <= cfg_data;
				ebzp_pkg::REG_END:   ep_q <= cfg_data;
				ebzp_pkg::REG_DUR:   dur_q <= cfg_data[TB-1:0];
				ebzp_pkg::REG_EIN:   ein_q <= cfg_data[TB-1:0];
				ebzp_pkg::REG_EOUT:  eout_q <= cfg_data[TB-1:0];
				default: ;
			endcase
		end
	end

	// Window tests on the timer before this tick.
	logic signed [TB+1:0] real_w, dmo_w;
	logic [TB+1:0] denom_w;
	always_comb begin
		dmo_w  = $signed({2'b00, dur_q}) - $signed({2'b00, eout_q});
		real_w = dmo_w - $signed({2'b00, ein_q});
		if (real_w < $signed((TB+2)'(65536))) real_w = (TB+2)'(65536);
		denom_w = $unsigned(real_w) + (TB+2)'(ein_q >> 1) + (TB+2)'(eout_q >> 1);
	end
	assign sts.ein_active  = tim_q < ein_q;
	assign sts.eout_active = (eout_q != '0) && ($signed({2'b00, tim_q}) > dmo_w);
	assign sts.div_done    = dbusy_q == 1'b0 && cmd.start == 1'b0;

	// Multiplier operands: one 34x34 product per cycle at most.
	logic [33:0] ma, mb;
	logic [67:0] prod;
	logic [16:0] uclamp;
	logic [17:0] lin;
	always_comb begin
		uclamp = (u_q > 17'd65536) ? 17'd65536 : u_q;
		lin = 18'd196608 - {uclamp, 1'b0};
		ma = '0; mb = '0;
		case (cmd.op)
			ebzp_pkg::OP_SMIN1, ebzp_pkg::OP_SMOUT1: begin
				ma = 34'(uclamp); mb = 34'(uclamp);
			end
			ebzp_pkg::OP_SMIN2, ebzp_pkg::OP_SMOUT2: begin
				ma = uu_q; mb = 34'(lin);
			end
			ebzp_pkg::OP_APPIN, ebzp_pkg::OP_APPOUT: begin
				ma = 34'(rate_q); mb = 34'(u_q);
			end
			ebzp_pkg::OP_INC: begin ma = 34'(rate_q); mb = 34'(dt_q); end
			ebzp_pkg::OP_WGT1: begin
				ma = 34'(POne - par_q); mb = 34'(POne - par_q);
			end
			ebzp_pkg::OP_WGT2: begin ma = 34'(par_q); mb = 34'(par_q); end
			default: ;
		endcase
		prod = 68'(ma) * 68'(mb);
	end

	// The increment can reach 2^27, well past 1.0, before it saturates.
	logic signed [CB-1:0] cs, cc, ce;
	logic signed [CB+PF+3:0] term;
	logic [PF+4:0] sum_p;
	always_comb begin
		cs = sp_q[20*cmd.axis +: CB];
		cc = cp_q[20*cmd.axis +: CB];
		ce = ep_q[20*cmd.axis +: CB];
		term = $signed({1'b0, a_q}) * cs + $signed({1'b0, b_q}) * cc
			+ $signed({1'b0, c_q}) * ce;
		sum_p = (PF+5)'(par_q) + prod[16 +: PF+5];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q <= '0; tim_q <= '0; dbusy_q <= 1'b0; done_q <= 1'b0;
			dcnt_q <= '0; dnum_q <= '0; drem_q <= '0; dden_q <= '0;
			dt_q <= '0; rate_q <= '0; u_q <= '0; uu_q <= '0;
			a_q <= '0; b_q <= '0; c_q <= '0; acc_q <= '0;
			px_q <= '0; py_q <= '0; pz_q <= '0;
		end else begin
			if (cmd.load) dt_q <= step_in;
			if (cmd.start) begin
				dbusy_q <= 1'b1;
				dcnt_q  <= 6'd40;
				drem_q  <= '0;
				case (cmd.op)
					ebzp_pkg::OP_DIVR: begin
						dnum_q <= 40'h80_0000_0000; dden_q <= denom_w;
					end
					ebzp_pkg::OP_DIVIN: begin
						dnum_q <= 40'({tim_q, 16'h0}); dden_q <= 26'(ein_q);
					end
					default: begin
						dnum_q <= (tim_q < dur_q) ? 40'({dur_q - tim_q, 16'h0}) : '0;
						dden_q <= 26'(eout_q);
					end
				endcase
			end else if (dbusy_q) begin
				if ({drem_q[25:0], dnum_q[39]} >= {1'b0, dden_q}) begin
					drem_q <= {drem_q[25:0], dnum_q[39]} - {1'b0, dden_q};
					dnum_q <= {dnum_q[38:0], 1'b1};
				end else begin
					drem_q <= {drem_q[25:0], dnum_q[39]};
					dnum_q <= {dnum_q[38:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == 6'd1) dbusy_q <= 1'b0;
			end
			case (cmd.op)
				ebzp_pkg::OP_DIVIN, ebzp_pkg::OP_DIVOUT:
					if (!cmd.start && !dbusy_q) u_q <= dnum_q[16:0];
				ebzp_pkg::OP_DIVR:
					if (!cmd.start && !dbusy_q) rate_q <= dnum_q[PF:0];
				ebzp_pkg::OP_SMIN1, ebzp_pkg::OP_SMOUT1: uu_q <= prod[33:0];
				ebzp_pkg::OP_SMIN2, ebzp_pkg::OP_SMOUT2: u_q <= prod[48:32];
				ebzp_pkg::OP_APPIN, ebzp_pkg::OP_APPOUT: rate_q <= prod[16 +: PF+1];
				ebzp_pkg::OP_INC:
					par_q <= (sum_p > (PF+5)'(POne)) ? POne : sum_p[PF:0];
				ebzp_pkg::OP_WGT1: begin
					a_q <= prod[PF +: PF+1];
					b_q <= (PF+1)'((68'(POne - par_q) * 68'(par_q)) >> (PF-1));
				end
				ebzp_pkg::OP_WGT2: c_q <= prod[PF +: PF+1];
				ebzp_pkg::OP_ACC: begin
					acc_q <= term;
				end
				ebzp_pkg::OP_FIN: begin
					case (cmd.axis)
						2'd0: px_q <= CB'(acc_q >>> PF);
						2'd1: py_q <= CB'(acc_q >>> PF);
						default: pz_q <= CB'(acc_q >>> PF);
					endcase
					if (cmd.axis == 2'd2) begin
						if ((TB+1)'(tim_q) + (TB+1)'(dt_q) > (TB+1)'(TMax)) begin
							tim_q <= TMax;
							done_q <= TMax >= dur_q;
						end else begin
							tim_q <= tim_q + TB'(dt_q);
							done_q <= tim_q + TB'(dt_q) >= dur_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign px = px_q;
	assign py = py_q;
	assign pz = pz_q;
	assign done_flag = done_q;
endmodule

// ===== hdl/ebzp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ebzp_ctrl
// Sequencer that steps the datapath through one tick and owns the handshakes.
// ----------------------------------------------------------------------------
module ebzp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  ebzp_pkg::sts_t sts,
	output ebzp_pkg::cmd_t cmd
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_AXIS = 6'b001000,
		ST_OUT  = 6'b010000,
		ST_SPARE = 6'b100000
	} state_t;

	state_t        state_q;
	ebzp_pkg::op_t op_q;
	logic          start_q;
	logic [1:0]    axis_q;

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = state_q == ST_OUT;
	assign cmd.op    = op_q;
	assign cmd.start = start_q;
	assign cmd.load  = (state_q == ST_IDLE) && in_valid;
	assign cmd.axis  = axis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; op_q <= ebzp_pkg::OP_NONE; start_q <= 1'b0;
			axis_q <= '0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) begin
					op_q <= ebzp_pkg::OP_SETUP; state_q <= ST_MUL;
				end
				ST_DIV: if (!start_q && sts.div_done) state_q <= ST_MUL;
				ST_MUL: begin
					// Pick the next step of the tick.
					case (op_q)
						ebzp_pkg::OP_SETUP: begin
							op_q <= ebzp_pkg::OP_DIVR; start_q <= 1'b1; state_q <= ST_DIV;
						end
						ebzp_pkg::OP_DIVR: begin
							if (sts.ein_active) begin
								op_q <= ebzp_pkg::OP_DIVIN; start_q <= 1'b1; state_q <= ST_DIV;
							end else if (sts.eout_active) begin
								op_q <= ebzp_pkg::OP_DIVOUT; start_q <= 1'b1; state_q <= ST_DIV;
							end else op_q <= ebzp_pkg::OP_INC;
						end
						ebzp_pkg::OP_DIVIN:  op_q <= ebzp_pkg::OP_SMIN1;
						ebzp_pkg::OP_SMIN1:  op_q <= ebzp_pkg::OP_SMIN2;
						ebzp_pkg::OP_SMIN2:  op_q <= ebzp_pkg::OP_APPIN;
						ebzp_pkg::OP_APPIN: begin
							if (sts.eout_active) begin
								op_q <= ebzp_pkg::OP_DIVOUT; start_q <= 1'b1; state_q <= ST_DIV;
							end else op_q <= ebzp_pkg::OP_INC;
						end
						ebzp_pkg::OP_DIVOUT: op_q <= ebzp_pkg::OP_SMOUT1;
						ebzp_pkg::OP_SMOUT1: op_q <= ebzp_pkg::OP_SMOUT2;
						ebzp_pkg::OP_SMOUT2: op_q <= ebzp_pkg::OP_APPOUT;
						ebzp_pkg::OP_APPOUT: op_q <= ebzp_pkg::OP_INC;
						ebzp_pkg::OP_INC:    op_q <= ebzp_pkg::OP_WGT1;
						ebzp_pkg::OP_WGT1:   op_q <= ebzp_pkg::OP_WGT2;
						default: begin
							op_q <= ebzp_pkg::OP_ACC; axis_q <= 2'd0;
							state_q <= ST_AXIS;
						end
					endcase
				end
				ST_AXIS: begin
					if (op_q == ebzp_pkg::OP_ACC) op_q <= ebzp_pkg::OP_FIN;
					else if (axis_q == 2'd2) begin
						op_q <= ebzp_pkg::OP_NONE; state_q <= ST_OUT;
					end else begin
						axis_q <= axis_q + 2'd1; op_q <= ebzp_pkg::OP_ACC;
					end
				end
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/ebzp_checker.sv =====
// ----------------------------------------------------------------------------
// ebzp_checker
// Port-level checks of the path generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ebzp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [ebzp_pkg::CoordBits-1:0] pos_x,
	input logic move_done
);
	// A tick is never taken while a result is on offer.
	`ASSERT_IMPL(a_no_take_with_out, clk, arst_n, out_valid, in_stall)
	// A result waiting on the receiver keeps its value.
	`ASSERT_NEXT(a_hold_x, clk, arst_n, out_valid && out_stall, $stable(pos_x))
	`ASSERT_NEXT(a_hold_done, clk, arst_n, out_valid && out_stall, $stable(move_done))
	// An accepted tick never yields a result in the very next cycle.
	`ASSERT_NEXT(a_latency, clk, arst_n, in_valid && !in_stall, !out_valid)
endmodule

bind eased_quadratic_bezier_path ebzp_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .pos_x, .move_done
);
